// ----- rtl/core/tmht_pkg.sv -----
// package for the trusted mac hash table
// holds sizes, command and state codes, the update struct and the bucket hash
// no dependencies
package tmht_pkg;

    localparam int BUCKETS = 128;
    localparam int WAYS    = 4;

    localparam int MAC_W   = 48;
    localparam int ENTRY_W = MAC_W + 1;
    localparam int ROW_W   = WAYS * ENTRY_W;
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int KEY_W   = 16;

    localparam logic [BKT_W-1:0] LAST_ROW = BKT_W'(BUCKETS - 1);
    localparam logic [31:0]      RECIP    = 32'((64'd1 << 32) / BUCKETS);

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_MODIFY
    } t_state;

    typedef struct packed {
        logic found;
        logic status;
        logic wr_en;
    } t_upd;

    // key = (o3 << 8) | (o4 << 4) | o5, reduced modulo the bucket count
    function automatic logic [BKT_W-1:0] bucket_of(input logic [MAC_W-1:0] a);
        logic [KEY_W-1:0] key;
        logic [47:0]      prod;
        logic [15:0]      q;
        logic [31:0]      qb;
        logic [KEY_W-1:0] r;
        key  = {a[23:16], 8'h00} | {4'h0, a[15:8], 4'h0} | {8'h00, a[7:0]};
        prod = 48'(key) * 48'(RECIP);
        q    = prod[47:32];
        qb   = 32'(q) * 32'(BUCKETS);
        r    = key - qb[KEY_W-1:0];
        if (r >= KEY_W'(BUCKETS)) begin
            r = r - KEY_W'(BUCKETS);
        end
        return r[BKT_W-1:0];
    endfunction

endpackage

// ----- rtl/core/tmht_if.sv -----
// command and response channel interfaces of the trusted mac hash table
// depends on tmht_pkg
interface tmht_cmd_if;
    import tmht_pkg::*;
    logic               valid;
    logic               ready;
    t_cmd               command;
    logic [MAC_W-1:0]   mac_address;

    modport source(output valid, command, mac_address, input ready);
    modport sink(input valid, command, mac_address, output ready);
endinterface

interface tmht_rsp_if;
    logic valid;
    logic ready;
    logic found;
    logic status;

    modport source(output valid, found, status, input ready);
    modport sink(input valid, found, status, output ready);
endinterface

// ----- rtl/core/tmht_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module tmht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/tmht_row_upd.sv -----
// bucket row update: way match, free way pick and write-back row
// depends on tmht_pkg
module tmht_row_upd (
    input  tmht_pkg::t_cmd                i_cmd,
    input  logic [tmht_pkg::MAC_W-1:0]    i_mac,
    input  logic [tmht_pkg::ROW_W-1:0]    i_row,
    output logic [tmht_pkg::ROW_W-1:0]    o_row,
    output tmht_pkg::t_upd                o_upd
);
    import tmht_pkg::*;

    logic [WAYS-1:0] valid;
    logic [WAYS-1:0] hit;
    logic [WAYS-1:0] free;
    logic [WAYS-1:0] free_1h;
    logic            any_hit;
    logic            full;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            valid[w] = i_row[w*ENTRY_W + MAC_W];
            hit[w]   = valid[w] && (i_row[w*ENTRY_W +: MAC_W] == i_mac);
        end
        free    = ~valid;
        free_1h = free & (~free + WAYS'(1));
        any_hit = |hit;
        full    = ~|free;
    end

    always_comb begin
        o_row = i_row;
        o_upd = '0;
        unique case (i_cmd)
            CMD_LOOKUP: begin
                o_upd.found = any_hit;
            end
            CMD_ADD: begin
                o_upd.found  = any_hit;
                o_upd.status = !any_hit && full;
                o_upd.wr_en  = !any_hit && !full;
                for (int w = 0; w < WAYS; w++) begin
                    if (free_1h[w]) begin
                        o_row[w*ENTRY_W +: ENTRY_W] = {1'b1, i_mac};
                    end
                end
            end
            CMD_DELETE: begin
                o_upd.found = any_hit;
                o_upd.wr_en = any_hit;
                for (int w = 0; w < WAYS; w++) begin
                    if (hit[w]) begin
                        o_row[w*ENTRY_W + MAC_W] = 1'b0;
                    end
                end
            end
            CMD_CLEAR: begin
                o_upd = '0;
            end
            default: begin
                o_upd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/trusted_mac_hash_table.sv -----
// trusted mac hash table top level: command fsm, bucket row ram, response register
// depends on tmht_pkg, tmht_if, tmht_ram and tmht_row_upd
//
// i_cmd carries one command with a 48-bit address: lookup, add, delete or
// clear; o_rsp returns one transfer per command with found and status.
// each bucket is one ram row of WAYS entries (valid bit plus address).
// lookup, add and delete read the row in the transfer cycle; it is modified and
// written back in S_MODIFY once the response register is free, and that
// register is loaded in the same cycle. one command is in flight at a time,
// so a new command is taken only after the read then write-back of one ram
// row. clear sweeps every row, one per cycle, and then answers from S_MODIFY
// like the other commands. after reset the same sweep runs with i_cmd.ready
// low. a held response does not block the next command transfer; the row
// write-back waits until the response register is free, so a stalled
// receiver stalls the block after one more command.
module trusted_mac_hash_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tmht_cmd_if.sink      i_cmd,
    tmht_rsp_if.source    o_rsp
);
    import tmht_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [BKT_W-1:0]  r_row;
    logic [BKT_W-1:0]  n_row;
    t_cmd              r_cmd;
    logic [MAC_W-1:0]  r_mac;
    logic [BKT_W-1:0]  r_bkt;
    logic              r_out_valid;
    logic              r_found;
    logic              r_status;

    logic              in_xfer;
    logic              in_ready;
    logic              out_free;
    logic              out_load;
    logic              mem_re;
    logic              mem_we;
    logic [BKT_W-1:0]  mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic [BKT_W-1:0]  mem_raddr;
    logic [ROW_W-1:0]  mem_rdata;
    logic [ROW_W-1:0]  upd_row;
    t_upd              upd;

    assign in_xfer   = i_cmd.valid && in_ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign mem_raddr = bucket_of(i_cmd.mac_address);

    tmht_ram #(
        .WIDTH(ROW_W),
        .DEPTH(BUCKETS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    tmht_row_upd u_row_upd (
        .i_cmd(r_cmd),
        .i_mac(r_mac),
        .i_row(mem_rdata),
        .o_row(upd_row),
        .o_upd(upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        in_ready  = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_row;
        mem_wdata = '0;
        out_load  = 1'b0;
        unique case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                if (r_row == LAST_ROW) begin
                    n_row   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_row = r_row + BKT_W'(1);
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_cmd.valid) begin
                    if (i_cmd.command == CMD_CLEAR) begin
                        n_row   = '0;
                        n_state = S_CLEAR;
                    end else begin
                        mem_re  = 1'b1;
                        n_state = S_MODIFY;
                    end
                end
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_row == LAST_ROW) begin
                    n_row   = '0;
                    n_state = S_MODIFY;
                end else begin
                    n_row = r_row + BKT_W'(1);
                end
            end
            S_MODIFY: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    mem_we    = upd.wr_en;
                    mem_waddr = r_bkt;
                    mem_wdata = upd_row;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_row   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd <= i_cmd.command;
            r_mac <= i_cmd.mac_address;
            r_bkt <= mem_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_found  <= upd.found;
            r_status <= upd.status;
        end
    end

    assign i_cmd.ready  = in_ready;
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.found  = r_found;
    assign o_rsp.status = r_status;

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_re && mem_we))
        else $error("ram read and write in the same cycle");

    a_lookup_to_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_cmd.command != CMD_CLEAR) |=> (r_state == S_MODIFY))
        else $error("row command did not move to modify");

    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status) |-> !o_rsp.found)
        else $error("full status together with found");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_cmd == CMD_CLEAR) |=> (!o_rsp.found && !o_rsp.status))
        else $error("clear response not zero");

endmodule
